FILE: design/kcab_pkg.sv
// ----------------------------------------------------------------------------
// Keyword cipher alphabet builder package
// Shared constants, payload structs and the back-end state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kcab_pkg;

  // Alphabet geometry.
  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int IDX_W         = $clog2(ALPHABET_SIZE);
  localparam int CNT_W         = $clog2(ALPHABET_SIZE + 1);
  localparam int SHIFT_W       = 5;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One keyword letter transaction.
  typedef struct packed {
    logic [LETTER_W-1:0] key_letter;
    logic                key_end;
  } key_item_t;

  // One substitution table row transaction.
  typedef struct packed {
    logic [LETTER_W-1:0] plain_letter;
    logic [LETTER_W-1:0] cipher_letter;
    logic                row_last;
  } row_item_t;

  // Classified command passed from front to back.
  typedef struct packed {
    logic [IDX_W-1:0] letter;
    logic             append;
    logic             last;
  } kcab_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_TAKE,
    B_FILL,
    B_EMIT
  } kcab_state_t;

endpackage

`default_nettype wire

FILE: design/kcab_front.sv
// ----------------------------------------------------------------------------
// Keyword cipher front end
// Accepts keyword letters, drops repeats and out-of-range letters, and
// forwards append and end commands to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kcab_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire kcab_pkg::key_item_t key_item,
  output logic                    full,
  output logic                    q_push,
  output kcab_pkg::kcab_cmd_t     q_cmd,
  input  wire logic               q_full
);
  import kcab_pkg::*;

  localparam logic [LETTER_W-1:0] SIZE_LETTER = LETTER_W'(ALPHABET_SIZE);

  logic [ALPHABET_SIZE-1:0] used_mask;
  logic                     accept;
  logic                     in_range;
  logic                     append;
  logic [IDX_W-1:0]         letter_idx;

  // Classify the incoming letter against the letters already seen.
  assign full       = q_full;
  assign accept     = push && !q_full;
  assign in_range   = key_item.key_letter < SIZE_LETTER;
  assign letter_idx = IDX_W'(key_item.key_letter);
  assign append     = in_range && !used_mask[letter_idx];

  // Only letters that change the table, or the end mark, go to the queue.
  assign q_push        = accept && (append || key_item.key_end);
  assign q_cmd.letter  = letter_idx;
  assign q_cmd.append  = append;
  assign q_cmd.last    = key_item.key_end;

  // The seen-letter mask restarts after the end mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_mask <= '0;
    end else if (accept) begin
      if (key_item.key_end) begin
        used_mask <= '0;
      end else if (append) begin
        used_mask[letter_idx] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/kcab_queue.sv
// ----------------------------------------------------------------------------
// Keyword cipher command queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module kcab_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_push,
  input  wire kcab_pkg::kcab_cmd_t q_din,
  output logic                     q_full,
  input  wire logic                q_pop,
  output kcab_pkg::kcab_cmd_t      q_dout,
  output logic                     q_empty
);
  import kcab_pkg::*;

  localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

  kcab_cmd_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign q_full  = count == DEPTH_CNT;
  assign q_empty = count == '0;
  assign q_dout  = entries[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_din;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/kcab_back.sv
// ----------------------------------------------------------------------------
// Keyword cipher back end
// Builds the mixed alphabet in a table memory, fills in the unused letters
// and emits the rotated table one row at a time through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kcab_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [kcab_pkg::SHIFT_W-1:0] shift,
  input  wire kcab_pkg::kcab_cmd_t    q_cmd,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output kcab_pkg::row_item_t         row_item,
  output logic                        empty,
  input  wire logic                   pop
);
  import kcab_pkg::*;

  localparam logic [CNT_W-1:0]   SIZE_CNT  = CNT_W'(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [SHIFT_W-1:0] SIZE_SHFT = SHIFT_W'(ALPHABET_SIZE);

  kcab_state_t              state;
  kcab_state_t              state_next;

  logic [LETTER_W-1:0]      table_mem [ALPHABET_SIZE];
  logic [LETTER_W-1:0]      rd_data;
  logic [ALPHABET_SIZE-1:0] used_mask;
  logic [CNT_W-1:0]         fill_count;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         src;
  logic [IDX_W-1:0]         pend_row;
  logic                     rd_pend;
  logic                     out_valid;

  logic                     mem_we;
  logic [LETTER_W-1:0]      mem_wdata;
  logic                     rd_issue;
  logic                     room;

  logic [SHIFT_W-1:0]       shift_mod;
  logic [IDX_W-1:0]         src_start;

  // Rotation start: the first row reads entry (0 - shift) mod size.
  assign shift_mod = (shift >= SIZE_SHFT) ? shift - SIZE_SHFT : shift;
  assign src_start = (shift_mod == '0) ? '0 : IDX_W'(SIZE_SHFT - shift_mod);

  assign room  = fill_count < SIZE_CNT;
  assign empty = !out_valid;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      B_TAKE: begin
        if (!q_empty && q_cmd.last) begin
          state_next = B_FILL;
        end
      end
      B_FILL: begin
        if (row == LAST_IDX) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (rd_issue && row == LAST_IDX) begin
          state_next = B_TAKE;
        end
      end
      default: state_next = B_TAKE;
    endcase
  end

  // Datapath control.
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    rd_issue  = 1'b0;
    unique case (state)
      B_TAKE: begin
        q_pop     = !q_empty;
        mem_we    = !q_empty && q_cmd.append && room;
        mem_wdata = LETTER_W'(q_cmd.letter);
      end
      B_FILL: begin
        mem_we    = !used_mask[row] && room;
        mem_wdata = LETTER_W'(row);
      end
      B_EMIT: begin
        rd_issue = !rd_pend && (!out_valid || pop);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[fill_count[IDX_W-1:0]] <= mem_wdata;
    end
    if (rd_issue) begin
      rd_data <= table_mem[src];
    end
  end

  // Sequencer state, fill bookkeeping and row counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_TAKE;
      used_mask  <= '0;
      fill_count <= '0;
      row        <= '0;
      src        <= '0;
      rd_pend    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (mem_we) begin
        fill_count <= fill_count + 1'b1;
      end
      if (state == B_TAKE && !q_empty && q_cmd.append) begin
        used_mask[q_cmd.letter] <= 1'b1;
      end
      if (state == B_FILL) begin
        if (row == LAST_IDX) begin
          row <= '0;
          src <= src_start;
        end else begin
          row <= row + 1'b1;
        end
      end
      if (rd_issue) begin
        src <= (src == LAST_IDX) ? '0 : src + 1'b1;
        if (row == LAST_IDX) begin
          // Last row read: the table is free for the next keyword.
          row        <= '0;
          used_mask  <= '0;
          fill_count <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  // Row index travels with its pending read.
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_row <= row;
    end
  end

  // Output register holds the oldest row until it is popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      row_item.plain_letter  <= LETTER_W'(pend_row);
      row_item.cipher_letter <= rd_data;
      row_item.row_last      <= pend_row == LAST_IDX;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= SIZE_CNT)
    else $error("table fill count exceeds alphabet size");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_FILL && state_next == B_EMIT) |=> fill_count == SIZE_CNT)
    else $error("table not complete when emission starts");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !out_valid)
    else $error("row read lands on an occupied output register");

  a_emit_no_write: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT |-> !mem_we && !q_pop)
    else $error("table written or command taken during emission");
`endif

endmodule

`default_nettype wire

FILE: design/keyword_cipher_alphabet_builder.sv
// ----------------------------------------------------------------------------
// Keyword cipher alphabet builder
// Top level: shift register, front end, command queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   Keyword letters enter on key_item with push/full; a transaction is taken
//   at each edge with push high and full low, one letter per cycle while the
//   command queue has room. Repeated and out-of-range letters are dropped.
//   A letter with key_end set closes the keyword: once it is taken from the
//   queue, the back end appends the unused letters in alphabet order, then
//   emits 26 rows on row_item with empty/pop, row_last on the final one.
//   Rows leave one at a time: a new registered read of the table memory
//   waits until the previous read has reached the single output register.
//   While the back end fills and emits, the front end keeps taking letters
//   of the next keyword until the four-entry command queue is full.
//   A stalled receiver holds the current row and pauses table reads.
//   The user must write the shift register with cfg_we/cfg_wdata only
//   while the block is idle; the block does not enforce this.
//   Synchronous reset clears the masks, counters, queue and shift.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_cipher_alphabet_builder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire kcab_pkg::key_item_t         key_item,
  output logic                             empty,
  input  wire logic                        pop,
  output kcab_pkg::row_item_t              row_item,
  input  wire logic                        cfg_we,
  input  wire logic [kcab_pkg::SHIFT_W-1:0] cfg_wdata
);
  import kcab_pkg::*;

  logic [SHIFT_W-1:0] shift;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  kcab_cmd_t          q_din;
  kcab_cmd_t          q_dout;

  // Rotation distance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
    end else if (cfg_we) begin
      shift <= cfg_wdata;
    end
  end

  kcab_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .key_item (key_item),
    .full     (full),
    .q_push   (q_push),
    .q_cmd    (q_din),
    .q_full   (q_full)
  );

  kcab_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_din   (q_din),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_dout  (q_dout),
    .q_empty (q_empty)
  );

  kcab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .shift    (shift),
    .q_cmd    (q_dout),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .row_item (row_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire
